// ===== design/wireframe_point_projection_top_assert.svh =====
`ifndef WIREFRAME_POINT_PROJECTION_TOP_ASSERT_SVH
`define WIREFRAME_POINT_PROJECTION_TOP_ASSERT_SVH

// Assertion helpers for the point projection pipeline. They expect clk_i and
// rst_ni in scope.

// Same-cycle implication.
`define WPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wpp_pkg.sv =====
package wpp_pkg;

  localparam int unsigned GridDimDefault = 1024;
  localparam int unsigned TrigFracBits   = 14;

  localparam int unsigned IdxW    = 10;
  localparam int unsigned TrigW   = 16;
  localparam int unsigned ZoomW   = 8;
  localparam int unsigned HScaleW = 21;
  localparam int unsigned HeightW = 16;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned CfgW    = 21;

  // Division by ten works on a 36-bit magnitude in three 12-bit chunks.
  localparam int unsigned DivChunkW = 12;
  localparam int unsigned DivMagW   = 3 * DivChunkW;
  localparam int unsigned ZW        = 35;
  localparam logic [15:0] Div10Mul  = 16'd52429;
  localparam int unsigned Div10Shift = 19;

  localparam logic [ColorW-1:0] ColorHigh = 24'hFF0000;
  localparam logic [ColorW-1:0] ColorLow  = 24'h00FF00;
  localparam logic signed [HeightW-1:0] HeightRed = 16'sd10;

  localparam logic signed [TrigW-1:0] TrigZeroRst = 16'sd0;
  localparam logic signed [TrigW-1:0] TrigOneRst  = 16'sd16384;
  localparam logic [ZoomW-1:0]        ZoomRst     = 8'd1;
  localparam logic [HScaleW-1:0]      HScaleRst   = 21'd1;

  typedef enum logic [2:0] {
    RegSinAlpha   = 3'd0,
    RegCosAlpha   = 3'd1,
    RegSinBeta    = 3'd2,
    RegCosBeta    = 3'd3,
    RegSinGamma   = 3'd4,
    RegCosGamma   = 3'd5,
    RegZoom       = 3'd6,
    RegHeightScale = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [DivChunkW-1:0] quo;
    logic [3:0]           rem;
  } div_step_t;

  // Fixed-point product scaling, rounding toward zero.
  function automatic logic signed [63:0] tmul(input logic signed [63:0] p);
    logic signed [63:0] bias;
    bias = p[63] ? ((64'sd1 <<< TrigFracBits) - 64'sd1) : 64'sd0;
    return (p + bias) >>> TrigFracBits;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

endpackage

// ===== design/wpp_div10.sv =====
module wpp_div10 (
  input  logic                           clk_i,
  input  logic [2:0]                     en_i,
  input  logic signed [36:0]             prod_i,
  output logic signed [wpp_pkg::ZW-1:0]  z_o
);

  localparam int unsigned CW = wpp_pkg::DivChunkW;

  // One long-division digit: remainder below ten followed by a chunk.
  // The reciprocal is exact for numerators below 2^18.
  function automatic wpp_pkg::div_step_t div_step(input logic [3:0] r,
                                                  input logic [CW-1:0] c);
    logic [CW+3:0]   n;
    logic [31:0]     prod;
    wpp_pkg::div_step_t res;
    n = {r, c};
    prod = 32'(n) * 32'(wpp_pkg::Div10Mul);
    res.quo = CW'(prod >> wpp_pkg::Div10Shift);
    res.rem = 4'(n - 16'(res.quo) * 16'd10);
    return res;
  endfunction

  logic [wpp_pkg::DivMagW-1:0] mag;
  wpp_pkg::div_step_t          st_a, st_b, st_c;

  logic [CW-1:0]   qa_q;
  logic [3:0]      ra_q;
  logic [2*CW-1:0] la_q;
  logic            nega_q;
  logic [2*CW-1:0] qb_q;
  logic [3:0]      rb_q;
  logic [CW-1:0]   lb_q;
  logic            negb_q;
  logic signed [wpp_pkg::ZW-1:0] z_q;

  assign mag  = wpp_pkg::DivMagW'(prod_i[36] ? -prod_i : prod_i);
  assign st_a = div_step(4'd0, mag[3*CW-1:2*CW]);
  assign st_b = div_step(ra_q, la_q[2*CW-1:CW]);
  assign st_c = div_step(rb_q, lb_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      qa_q   <= st_a.quo;
      ra_q   <= st_a.rem;
      la_q   <= mag[2*CW-1:0];
      nega_q <= prod_i[36];
    end
    if (en_i[1]) begin
      qb_q   <= {qa_q, st_b.quo};
      rb_q   <= st_b.rem;
      lb_q   <= la_q[CW-1:0];
      negb_q <= nega_q;
    end
    if (en_i[2]) begin
      // Quotient of the magnitude, then the sign back on: truncation toward zero.
      z_q <= negb_q ? -wpp_pkg::ZW'({qb_q, st_c.quo})
                    : wpp_pkg::ZW'({qb_q, st_c.quo});
    end
  end

  assign z_o = z_q;

endmodule

// ===== design/wireframe_point_projection_top.sv =====
// Point projection pipeline: eight register stages; an accepted item moves through
// them in order, and out_valid_o rises when it reaches the stage 8 output register.
// Throughput is one item per cycle while out_stall_i is low; each stage holds
// one item and a bubble is filled while a later stage waits on out_stall_i.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// rotation, zoom and height scale registers with their identity defaults.
`include "wireframe_point_projection_top_assert.svh"

module wireframe_point_projection_top #(
  parameter int unsigned GRID_DIM = wpp_pkg::GridDimDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [wpp_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wpp_pkg::IdxW-1:0]           column_i,
  input  logic [wpp_pkg::IdxW-1:0]           row_i,
  input  logic signed [wpp_pkg::HeightW-1:0] height_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 screen_x_o,
  output logic signed [31:0]                 screen_y_o,
  output logic [wpp_pkg::ColorW-1:0]         color_o
);

  localparam int unsigned IW     = wpp_pkg::IdxW;
  localparam int unsigned MaxIdx = GRID_DIM - 1;

  // Configuration registers.
  logic signed [15:0] sin_alpha_q, cos_alpha_q, sin_beta_q, cos_beta_q;
  logic signed [15:0] sin_gamma_q, cos_gamma_q;
  logic [wpp_pkg::ZoomW-1:0]   zoom_q;
  logic [wpp_pkg::HScaleW-1:0] hscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_alpha_q <= wpp_pkg::TrigZeroRst;
      cos_alpha_q <= wpp_pkg::TrigOneRst;
      sin_beta_q  <= wpp_pkg::TrigZeroRst;
      cos_beta_q  <= wpp_pkg::TrigOneRst;
      sin_gamma_q <= wpp_pkg::TrigZeroRst;
      cos_gamma_q <= wpp_pkg::TrigOneRst;
      zoom_q      <= wpp_pkg::ZoomRst;
      hscale_q    <= wpp_pkg::HScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wpp_pkg::RegSinAlpha:    sin_alpha_q <= cfg_wdata_i[15:0];
        wpp_pkg::RegCosAlpha:    cos_alpha_q <= cfg_wdata_i[15:0];
        wpp_pkg::RegSinBeta:     sin_beta_q  <= cfg_wdata_i[15:0];
        wpp_pkg::RegCosBeta:     cos_beta_q  <= cfg_wdata_i[15:0];
        wpp_pkg::RegSinGamma:    sin_gamma_q <= cfg_wdata_i[15:0];
        wpp_pkg::RegCosGamma:    cos_gamma_q <= cfg_wdata_i[15:0];
        wpp_pkg::RegZoom:        zoom_q      <= cfg_wdata_i[wpp_pkg::ZoomW-1:0];
        wpp_pkg::RegHeightScale: hscale_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance. A stage moves when it is empty or
  // the stage after it moves.
  logic [7:0] v_q;
  logic [7:0] en;

  always_comb begin
    en[7] = !v_q[7] || !out_stall_i;
    for (int k = 6; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 8; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: clamp indices, zoom, and raw lifted height product.
  logic [IW-1:0] col_c, row_c;
  logic [17:0]        xs1_q, ys1_q;
  logic signed [36:0] p1_q;
  logic               red1_q;

  assign col_c = (32'(column_i) > MaxIdx) ? IW'(MaxIdx) : column_i;
  assign row_c = (32'(row_i) > MaxIdx) ? IW'(MaxIdx) : row_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      xs1_q  <= 18'(col_c) * 18'(zoom_q);
      ys1_q  <= 18'(row_c) * 18'(zoom_q);
      p1_q   <= 37'(height_i) * 37'(signed'({1'b0, hscale_q}));
      red1_q <= (height_i >= wpp_pkg::HeightRed);
    end
  end

  // Stages 2 to 4 also run the divide-by-ten of the height product.
  logic signed [wpp_pkg::ZW-1:0] z4;

  wpp_div10 u_div10 (
    .clk_i  (clk_i),
    .en_i   (en[3:1]),
    .prod_i (p1_q),
    .z_o    (z4)
  );

  // Stage 2: first rotation products.
  logic signed [18:0] xs_s, ys_s;
  logic signed [34:0] pxcg2_q, pysg2_q, pxsg2_q, pyca2_q;
  logic               red2_q;

  assign xs_s = signed'({1'b0, xs1_q});
  assign ys_s = signed'({1'b0, ys1_q});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pxcg2_q <= 35'(xs_s) * 35'(cos_gamma_q);
      pysg2_q <= 35'(ys_s) * 35'(sin_gamma_q);
      pxsg2_q <= 35'(xs_s) * 35'(sin_gamma_q);
      pyca2_q <= 35'(ys_s) * 35'(cos_alpha_q);
      red2_q  <= red1_q;
    end
  end

  // Stage 3: scale back and form A.
  logic signed [20:0] txcg, tysg;
  logic signed [21:0] a3_q;
  logic signed [20:0] b3_q, tyca3_q;
  logic               red3_q;

  assign txcg = 21'(wpp_pkg::tmul(64'(pxcg2_q)));
  assign tysg = 21'(wpp_pkg::tmul(64'(pysg2_q)));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      a3_q    <= 22'(txcg) - 22'(tysg);
      b3_q    <= 21'(wpp_pkg::tmul(64'(pxsg2_q)));
      tyca3_q <= 21'(wpp_pkg::tmul(64'(pyca2_q)));
      red3_q  <= red2_q;
    end
  end

  // Stage 4: products on A and on the Y term.
  logic signed [37:0] pacb4_q, pasa4_q;
  logic signed [36:0] pycg4_q;
  logic signed [20:0] b4_q;
  logic               red4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pacb4_q <= 38'(a3_q) * 38'(cos_beta_q);
      pasa4_q <= 38'(a3_q) * 38'(sin_alpha_q);
      pycg4_q <= 37'(tyca3_q) * 37'(cos_gamma_q);
      b4_q    <= b3_q;
      red4_q  <= red3_q;
    end
  end

  // Stage 5: products on z, scale back the stage 4 products.
  logic signed [50:0] pzsb5_q, pzsa5_q;
  logic signed [23:0] tacb5_q, tasa5_q;
  logic signed [22:0] tycg5_q;
  logic signed [20:0] b5_q;
  logic               red5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      pzsb5_q <= 51'(z4) * 51'(sin_beta_q);
      pzsa5_q <= 51'(z4) * 51'(sin_alpha_q);
      tacb5_q <= 24'(wpp_pkg::tmul(64'(pacb4_q)));
      tasa5_q <= 24'(wpp_pkg::tmul(64'(pasa4_q)));
      tycg5_q <= 23'(wpp_pkg::tmul(64'(pycg4_q)));
      b5_q    <= b4_q;
      red5_q  <= red4_q;
    end
  end

  // Stage 6: screen x sum and the inner term of screen y.
  logic signed [36:0] tzsb, tzsa;
  logic signed [37:0] sx6_q, in6_q;
  logic signed [23:0] tasa6_q;
  logic signed [22:0] tycg6_q;
  logic               red6_q;

  assign tzsb = 37'(wpp_pkg::tmul(64'(pzsb5_q)));
  assign tzsa = 37'(wpp_pkg::tmul(64'(pzsa5_q)));

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sx6_q   <= 38'(tacb5_q) + 38'(tzsb);
      in6_q   <= 38'(tzsa) + 38'(b5_q);
      tasa6_q <= tasa5_q;
      tycg6_q <= tycg5_q;
      red6_q  <= red5_q;
    end
  end

  // Stage 7: last two products of screen y; screen x saturates here.
  logic signed [39:0] m1_7_q;
  logic signed [53:0] m2_7_q;
  logic signed [31:0] sx7_q;
  logic signed [22:0] tycg7_q;
  logic               red7_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      m1_7_q  <= 40'(tasa6_q) * 40'(sin_beta_q);
      m2_7_q  <= 54'(in6_q) * 54'(cos_beta_q);
      sx7_q   <= wpp_pkg::sat32(64'(sx6_q));
      tycg7_q <= tycg6_q;
      red7_q  <= red6_q;
    end
  end

  // Stage 8: output register.
  logic signed [63:0] sy_sum;
  logic signed [31:0] sx8_q, sy8_q;
  logic [wpp_pkg::ColorW-1:0] color8_q;

  assign sy_sum = wpp_pkg::tmul(64'(m1_7_q)) + wpp_pkg::tmul(64'(m2_7_q))
                + 64'(tycg7_q);

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      sx8_q    <= sx7_q;
      sy8_q    <= wpp_pkg::sat32(sy_sum);
      color8_q <= red7_q ? wpp_pkg::ColorHigh : wpp_pkg::ColorLow;
    end
  end

  assign out_valid_o = v_q[7];
  assign screen_x_o  = sx8_q;
  assign screen_y_o  = sy8_q;
  assign color_o     = color8_q;

  `WPP_ASSERT_IMPL(a_stall_full, in_stall_o, (&v_q) && out_stall_i, "input stalled with a free stage")
  `WPP_ASSERT_IMPL(a_color_code, out_valid_o, color_o == wpp_pkg::ColorHigh || color_o == wpp_pkg::ColorLow, "bad color")
  `WPP_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, v_q[0], "accepted item lost at entry")
  `WPP_ASSERT_NEXT(a_stage_move, v_q[6] && en[7], v_q[7], "item lost entering output stage")

endmodule

// ===== bench/wireframe_point_projection_check.sv =====
`timescale 1ns / 100ps

module wireframe_point_projection_check #(
  parameter int unsigned GRID_DIM = wpp_pkg::GridDimDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [wpp_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [wpp_pkg::IdxW-1:0]           column_i,
  input  logic [wpp_pkg::IdxW-1:0]           row_i,
  input  logic signed [wpp_pkg::HeightW-1:0] height_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [31:0]                 screen_x_i,
  input  logic signed [31:0]                 screen_y_i,
  input  logic [wpp_pkg::ColorW-1:0]         color_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);

  typedef struct packed {
    logic signed [31:0]         x;
    logic signed [31:0]         y;
    logic [wpp_pkg::ColorW-1:0] color;
  } screen_point_t;

  localparam longint TrigUnit = longint'(1) << wpp_pkg::TrigFracBits;
  localparam longint GridLast = longint'(GRID_DIM) - 1;
  localparam longint S32Max   = 64'sd2147483647;
  localparam longint S32Min   = -64'sd2147483648;

  screen_point_t projected_points[$];

  // Local copy of the rotation, zoom and height scale registers.
  longint sin_a, cos_a, sin_b, cos_b, sin_g, cos_g;
  longint zoom_f, height_scale;

  // Fixed-point product, rounded toward zero.
  function automatic longint trig_scale(input longint v, input longint c);
    return (v * c) / TrigUnit;
  endfunction

  function automatic logic signed [31:0] clip_s32(input longint v);
    longint r;
    r = v;
    if (r > S32Max) r = S32Max;
    if (r < S32Min) r = S32Min;
    return r[31:0];
  endfunction

  function automatic longint grid_index(input logic [wpp_pkg::IdxW-1:0] v);
    longint idx;
    idx = longint'(v);
    if (idx > GridLast) idx = GridLast;
    return idx;
  endfunction

  function automatic screen_point_t project_point(
    input logic [wpp_pkg::IdxW-1:0]           col,
    input logic [wpp_pkg::IdxW-1:0]           row,
    input logic signed [wpp_pkg::HeightW-1:0] height
  );
    longint        lifted, xs, ys, rot, sx, sy;
    screen_point_t res;
    lifted = (longint'(height) * height_scale) / 10;
    xs     = grid_index(col) * zoom_f;
    ys     = grid_index(row) * zoom_f;
    rot    = trig_scale(xs, cos_g) - trig_scale(ys, sin_g);
    sx     = trig_scale(rot, cos_b) + trig_scale(lifted, sin_b);
    sy     = trig_scale(trig_scale(rot, sin_a), sin_b)
           + trig_scale(trig_scale(lifted, sin_a) + trig_scale(xs, sin_g), cos_b)
           + trig_scale(trig_scale(ys, cos_a), cos_g);
    res.x     = clip_s32(sx);
    res.y     = clip_s32(sy);
    res.color = (height >= wpp_pkg::HeightRed) ? wpp_pkg::ColorHigh : wpp_pkg::ColorLow;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    screen_point_t want;
    if (!rst_ni) begin
      sin_a        = longint'(wpp_pkg::TrigZeroRst);
      cos_a        = longint'(wpp_pkg::TrigOneRst);
      sin_b        = longint'(wpp_pkg::TrigZeroRst);
      cos_b        = longint'(wpp_pkg::TrigOneRst);
      sin_g        = longint'(wpp_pkg::TrigZeroRst);
      cos_g        = longint'(wpp_pkg::TrigOneRst);
      zoom_f       = longint'(wpp_pkg::ZoomRst);
      height_scale = longint'(wpp_pkg::HScaleRst);
      fail_count_o = 0;
      checked_o    = 0;
      projected_points.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        projected_points.push_back(project_point(column_i, row_i, height_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (projected_points.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no point outstanding: x %0d y %0d color %06h",
                   $time, screen_x_i, screen_y_i, color_i);
        end else begin
          want = projected_points.pop_front();
          checked_o++;
          if (screen_x_i !== want.x) begin
            fail_count_o++;
            $display("%0t: screen_x expected %0d, got %0d", $time, want.x, screen_x_i);
          end
          if (screen_y_i !== want.y) begin
            fail_count_o++;
            $display("%0t: screen_y expected %0d, got %0d", $time, want.y, screen_y_i);
          end
          if (color_i !== want.color) begin
            fail_count_o++;
            $display("%0t: color expected %06h, got %06h", $time, want.color, color_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (wpp_pkg::cfg_reg_e'(cfg_idx_i))
          wpp_pkg::RegSinAlpha: sin_a = longint'($signed(cfg_wdata_i[wpp_pkg::TrigW-1:0]));
          wpp_pkg::RegCosAlpha: cos_a = longint'($signed(cfg_wdata_i[wpp_pkg::TrigW-1:0]));
          wpp_pkg::RegSinBeta:  sin_b = longint'($signed(cfg_wdata_i[wpp_pkg::TrigW-1:0]));
          wpp_pkg::RegCosBeta:  cos_b = longint'($signed(cfg_wdata_i[wpp_pkg::TrigW-1:0]));
          wpp_pkg::RegSinGamma: sin_g = longint'($signed(cfg_wdata_i[wpp_pkg::TrigW-1:0]));
          wpp_pkg::RegCosGamma: cos_g = longint'($signed(cfg_wdata_i[wpp_pkg::TrigW-1:0]));
          wpp_pkg::RegZoom:     zoom_f = longint'(cfg_wdata_i[wpp_pkg::ZoomW-1:0]);
          wpp_pkg::RegHeightScale: height_scale = longint'(cfg_wdata_i[wpp_pkg::HScaleW-1:0]);
          default: ;
        endcase
      end
    end
    pending_o = projected_points.size();
  end

endmodule

// ===== bench/wireframe_point_projection_top_test.sv =====
`timescale 1ns / 100ps

module wireframe_point_projection_top_test;

  localparam int WatchdogLimit = 3000;
  localparam int PhasePoints   = 100;
  localparam int RandomPhases  = 7;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [2:0]                         cfg_idx = wpp_pkg::RegSinAlpha;
  logic [wpp_pkg::CfgW-1:0]           cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [wpp_pkg::IdxW-1:0]           column = '0;
  logic [wpp_pkg::IdxW-1:0]           row = '0;
  logic signed [wpp_pkg::HeightW-1:0] height = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [31:0]                 screen_x;
  logic signed [31:0]                 screen_y;
  logic [wpp_pkg::ColorW-1:0]         color;

  int fail_count, pending, checked;
  int send_idle_pct = 37;
  int recv_idle_pct = 59;
  int points_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int directed_points;

  always #5 clk = ~clk;

  wireframe_point_projection_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .column_i    (column),
    .row_i       (row),
    .height_i    (height),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .screen_x_o  (screen_x),
    .screen_y_o  (screen_y),
    .color_o     (color)
  );

  wireframe_point_projection_check checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .column_i     (column),
    .row_i        (row),
    .height_i     (height),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .screen_x_i   (screen_x),
    .screen_y_i   (screen_y),
    .color_i      (color),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Ends the run if the block stops moving items for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Holds the sender back until every outstanding point has come out,
  // then lets the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(input wpp_pkg::cfg_reg_e idx,
                         input logic [wpp_pkg::CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // The upper data bits above a register's width are filled with noise.
  function automatic logic [wpp_pkg::CfgW-1:0] trig_word(input int v);
    logic [wpp_pkg::TrigW-1:0] low;
    low = v[wpp_pkg::TrigW-1:0];
    return {5'($urandom), low};
  endfunction

  task automatic set_regs(input int sa, input int ca, input int sb, input int cb,
                          input int sg, input int cg, input int zm, input int hs);
    logic [wpp_pkg::ZoomW-1:0] zoom_bits;
    zoom_bits = zm[wpp_pkg::ZoomW-1:0];
    wait_drained();
    put_reg(wpp_pkg::RegSinAlpha, trig_word(sa));
    put_reg(wpp_pkg::RegCosAlpha, trig_word(ca));
    put_reg(wpp_pkg::RegSinBeta, trig_word(sb));
    put_reg(wpp_pkg::RegCosBeta, trig_word(cb));
    put_reg(wpp_pkg::RegSinGamma, trig_word(sg));
    put_reg(wpp_pkg::RegCosGamma, trig_word(cg));
    put_reg(wpp_pkg::RegZoom, {13'($urandom), zoom_bits});
    put_reg(wpp_pkg::RegHeightScale, hs[wpp_pkg::CfgW-1:0]);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_point(input logic [wpp_pkg::IdxW-1:0] c,
                            input logic [wpp_pkg::IdxW-1:0] r,
                            input logic signed [wpp_pkg::HeightW-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    column   <= c;
    row      <= r;
    height   <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
  endtask

  function automatic int rand_trig();
    int pick;
    pick = $urandom_range(19);
    if (pick < 14) return int'($urandom_range(32768)) - 16384;
    if (pick < 17) return ($urandom_range(1) != 0) ? 16384 : -16384;
    return int'($urandom_range(65535));
  endfunction

  function automatic int rand_zoom();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return $urandom_range(8);
    if (pick < 8) return $urandom_range(255);
    return ($urandom_range(1) != 0) ? 255 : 0;
  endfunction

  function automatic int rand_height_scale();
    case ($urandom_range(6))
      0, 1, 2: return $urandom_range(100);
      3, 4:    return $urandom_range(1048576);
      5:       return 1048576;
      default: return $urandom_range(2097151);
    endcase
  endfunction

  task automatic send_random_point();
    logic [wpp_pkg::IdxW-1:0]           c, r;
    logic signed [wpp_pkg::HeightW-1:0] h;
    c = 10'($urandom_range(1023));
    r = 10'($urandom_range(1023));
    if ($urandom_range(15) == 0) c = ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
    if ($urandom_range(15) == 0) r = ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
    // A quarter of the heights sit around the color threshold.
    if ($urandom_range(3) == 0) h = 16'(int'($urandom_range(24)) - 7);
    else h = 16'($urandom);
    send_point(c, r, h);
  endtask

  initial begin
    int fails;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity registers straight out of reset.
    send_point(10'd0, 10'd0, 16'sd0);
    send_point(10'd1023, 10'd1023, 16'sd32767);
    send_point(10'd1023, 10'd0, -16'sd32768);
    send_point(10'd5, 10'd7, 16'sd10);
    send_point(10'd5, 10'd7, 16'sd9);

    // A general rotation with a small height scale, so negative lifted
    // heights show truncation toward zero.
    set_regs(11585, 11585, -8192, 14189, 5000, -15000, 3, 3);
    send_point(10'd0, 10'd1023, -16'sd7);
    send_point(10'd1023, 10'd0, -16'sd1);
    send_point(10'd512, 10'd511, 16'sd10);
    send_point(10'd300, 10'd700, 16'sd9);
    send_point(10'd1, 10'd1, -16'sd32768);
    send_point(10'd1023, 10'd1023, 16'sd32767);
    send_point(10'd17, 10'd33, 16'sd11);

    // Largest zoom and height scale drive both coordinates into saturation.
    set_regs(16384, -16384, 16384, -16384, -16384, 16384, 255, 2097151);
    send_point(10'd1023, 10'd1023, 16'sd32767);
    send_point(10'd1023, 10'd1023, -16'sd32768);
    send_point(10'd0, 10'd0, 16'sd32767);
    send_point(10'd1023, 10'd0, -16'sd32768);
    send_point(10'd0, 10'd1023, 16'sd10);

    // Trig words outside the nominal range are taken as raw 16-bit values.
    set_regs(32768, 32768, 32768, 32768, 32768, 32768, 0, 0);
    send_point(10'd1023, 10'd1023, 16'sd32767);
    send_point(10'd1023, 10'd1023, -16'sd32768);
    send_point(10'd0, 10'd0, 16'sd10);

    set_regs(32767, 32767, 32767, 32767, 32767, 32767, 255, 1048576);
    send_point(10'd1023, 10'd1023, 16'sd32767);
    send_point(10'd1023, 10'd511, -16'sd32768);
    send_point(10'd0, 10'd1023, -16'sd10);
    directed_points = points_sent;

    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 59;
      end else if (ph < 5) begin
        send_idle_pct = 59;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_regs(rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(), rand_trig(),
               rand_zoom(), rand_height_scale());
      for (int k = 0; k < PhasePoints; k++) begin
        if (ph == 3 && k == PhasePoints / 2) wait_drained();
        send_random_point();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    fails = fail_count + ((pending != 0) ? 1 : 0);
    $display("Sent %0d grid points (%0d directed) under %0d register settings.",
             points_sent, directed_points, settings_used);
    $display("Compared %0d projected results across both idle patterns and a stall-free run.",
             checked);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
